// ===== design/essd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// essd_pkg: shared types and constants of the stitch stream decoder
// Parse phases, event codes, stream marker bytes and the result record.
// ----------------------------------------------------------------------------
package essd_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int MAX_BLOCKS_DEF = 256;

  localparam int BYTE_W  = 8;
  localparam int DELTA_W = 13;
  localparam int OUT_W   = 16;
  localparam int CFG_W   = 9;
  localparam int BLKO_W  = 8;

  localparam logic [BYTE_W-1:0] END_HI_BYTE   = 8'd255;
  localparam logic [BYTE_W-1:0] END_LO_BYTE   = 8'd0;
  localparam logic [BYTE_W-1:0] COLOR_HI_BYTE = 8'd254;
  localparam logic [BYTE_W-1:0] COLOR_LO_BYTE = 8'd176;
  localparam logic [BYTE_W-1:0] JUMP_MASK     = 8'h30;
  localparam int               LONG_BIT      = 7;
  localparam logic [CFG_W-1:0] COLOR_COUNT_RST = 9'd1;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_YFIRST,
    PH_YSECOND,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    EV_STITCH = 2'd0,
    EV_BLOCK  = 2'd1,
    EV_END    = 2'd2,
    EV_ERROR  = 2'd3
  } event_kind_t;

  typedef struct packed {
    event_kind_t              event_kind;
    logic signed [OUT_W-1:0]  pos_x;
    logic signed [OUT_W-1:0]  pos_y;
    logic                     jump;
    logic [BLKO_W-1:0]        block_index;
    logic signed [OUT_W-1:0]  box_min_x;
    logic signed [OUT_W-1:0]  box_max_x;
    logic signed [OUT_W-1:0]  box_min_y;
    logic signed [OUT_W-1:0]  box_max_y;
  } result_t;

  // Seven-bit signed delta carried in one byte.
  function automatic logic signed [DELTA_W-1:0] short_delta(input logic [BYTE_W-1:0] b);
    return {{(DELTA_W-7){b[6]}}, b[6:0]};
  endfunction

  // Twelve-bit signed delta: low nibble of the first byte, then the second byte.
  function automatic logic signed [DELTA_W-1:0] long_delta(input logic [BYTE_W-1:0] hi,
                                                           input logic [BYTE_W-1:0] lo);
    return {hi[3], hi[3:0], lo};
  endfunction

endpackage

`default_nettype wire

// ===== design/essd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// essd_in_if: byte input channel
// Valid/ready channel that carries one raw stream byte and its start flag.
// ----------------------------------------------------------------------------
interface essd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;

  modport source (output valid, output data_byte, output stream_start, input ready);
  modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

`default_nettype wire

// ===== design/essd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// essd_out_if: event output channel
// Valid/ready channel that carries one decoded stitch or stream event.
// ----------------------------------------------------------------------------
interface essd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               jump;
  logic [7:0]         block_index;
  logic signed [15:0] box_min_x;
  logic signed [15:0] box_max_x;
  logic signed [15:0] box_min_y;
  logic signed [15:0] box_max_y;

  modport source (output valid, output event_kind, output pos_x, output pos_y,
                  output jump, output block_index, output box_min_x, output box_max_x,
                  output box_min_y, output box_max_y, input ready);
  modport sink   (input valid, input event_kind, input pos_x, input pos_y,
                  input jump, input block_index, input box_min_x, input box_max_x,
                  input box_min_y, input box_max_y, output ready);
endinterface

`default_nettype wire

// ===== design/embroidery_stitch_stream_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// embroidery_stitch_stream_decoder: stitch section byte decoder
// Output: a byte that completes an event shows its result in the cycle after
//   the transaction that delivers it.
// Throughput: one byte per cycle unless the output stalls; the byte decode
//   and saturating add sit between the parse state registers and the result register.
// Reset: synchronous, active low; clears the parse state, empties the box
//   and sets color_count to 1. No clearing pass is needed.
// ----------------------------------------------------------------------------
module embroidery_stitch_stream_decoder #(
  parameter int COORD_BITS = essd_pkg::COORD_BITS_DEF,
  parameter int MAX_BLOCKS = essd_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  essd_in_if.sink         in_ch,
  essd_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_wdata
);
  import essd_pkg::*;

  // The parser decodes each byte against its stored phase and updates the
  // running position and bounding box in the same cycle. A byte that ends
  // a stitch or the end marker, or a color change after a non-empty block
  // (a block event or palette overflow), pushes one record into the result register.
  logic    res_push;
  logic    res_ready;
  result_t res;

  essd_core #(
    .COORD_BITS (COORD_BITS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_ready (res_ready),
    .res_push  (res_push),
    .res       (res)
  );

  // The result register holds a finished event until the sink takes it; the input
  // stalls only when it is full and not drained.
  essd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_ready (res_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== design/essd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// essd_core: stitch stream parser
// Holds the parse state, position and box, and decodes one byte per cycle while res_ready is high.
// ----------------------------------------------------------------------------
module essd_core #(
  parameter int COORD_BITS = essd_pkg::COORD_BITS_DEF,
  parameter int MAX_BLOCKS = essd_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  essd_in_if.sink                       in_ch,
  input  wire logic                     cfg_we,
  input  wire logic [8:0]               cfg_wdata,
  input  wire logic                     res_ready,
  output      logic                     res_push,
  output      essd_pkg::result_t        res
);
  import essd_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int BW = $clog2(MAX_BLOCKS + 1);

  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  logic [CFG_W-1:0] color_count_r;

  phase_t                    phase_r, phase_nxt;
  logic [BYTE_W-1:0]         held_r, held_nxt;
  logic signed [DELTA_W-1:0] pdx_r, pdx_nxt;
  logic                      jump_r, jump_nxt;
  logic signed [CB-1:0]      cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [CB-1:0]      min_x_r, min_x_nxt, max_x_r, max_x_nxt;
  logic signed [CB-1:0]      min_y_r, min_y_nxt, max_y_r, max_y_nxt;
  logic [BW-1:0]             blk_r, blk_nxt;
  logic                      nonempty_r, nonempty_nxt;
  logic                      done_r, done_nxt;

  logic                      accept;
  logic                      emit;
  event_kind_t               kind;
  logic                      stitch_go;
  logic signed [DELTA_W-1:0] sdx, sdy;
  logic [9:0]                lim, blk_p1;
  logic [BYTE_W-1:0]         b;

  function automatic logic signed [CB-1:0] sat_add(input logic signed [CB-1:0] a,
                                                   input logic signed [DELTA_W-1:0] d);
    logic signed [CB:0] s;
    s = {a[CB-1], a} + {{(CB+1-DELTA_W){d[DELTA_W-1]}}, d};
    if (s[CB] != s[CB-1]) begin
      return s[CB] ? CMIN : CMAX;
    end
    return s[CB-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [CB-1:0] v);
    logic [32:0] ext;
    ext = {{(33-CB){v[CB-1]}}, v};
    return ext[OUT_W-1:0];
  endfunction

  assign accept      = in_ch.valid && res_ready;
  assign in_ch.ready = res_ready;
  assign b           = in_ch.data_byte;

  always_comb begin
    lim = ({1'b0, color_count_r} > 10'(MAX_BLOCKS)) ? 10'(MAX_BLOCKS) : {1'b0, color_count_r};
  end

  always_comb begin
    // A start flag clears the state before the same byte is decoded.
    if (in_ch.stream_start) begin
      phase_nxt    = PH_FIRST;
      held_nxt     = '0;
      pdx_nxt      = '0;
      jump_nxt     = 1'b0;
      cur_x_nxt    = '0;
      cur_y_nxt    = '0;
      min_x_nxt    = CMAX;
      max_x_nxt    = CMIN;
      min_y_nxt    = CMAX;
      max_y_nxt    = CMIN;
      blk_nxt      = '0;
      nonempty_nxt = 1'b0;
      done_nxt     = 1'b0;
    end else begin
      phase_nxt    = phase_r;
      held_nxt     = held_r;
      pdx_nxt      = pdx_r;
      jump_nxt     = jump_r;
      cur_x_nxt    = cur_x_r;
      cur_y_nxt    = cur_y_r;
      min_x_nxt    = min_x_r;
      max_x_nxt    = max_x_r;
      min_y_nxt    = min_y_r;
      max_y_nxt    = max_y_r;
      blk_nxt      = blk_r;
      nonempty_nxt = nonempty_r;
      done_nxt     = done_r;
    end

    emit      = 1'b0;
    kind      = EV_STITCH;
    stitch_go = 1'b0;
    sdx       = pdx_nxt;
    sdy       = '0;
    blk_p1    = 10'(blk_nxt) + 10'd1;

    if (!done_nxt) begin
      unique case (phase_nxt)
        PH_FIRST: begin
          held_nxt  = b;
          jump_nxt  = 1'b0;
          phase_nxt = PH_SECOND;
        end
        PH_SECOND: begin
          if (held_nxt == END_HI_BYTE && b == END_LO_BYTE) begin
            done_nxt  = 1'b1;
            phase_nxt = PH_FIRST;
            emit      = 1'b1;
            kind      = EV_END;
          end else if (held_nxt == COLOR_HI_BYTE && b == COLOR_LO_BYTE) begin
            phase_nxt = PH_SKIP;
            if (nonempty_nxt) begin
              emit = 1'b1;
              if (blk_p1 >= lim) begin
                done_nxt  = 1'b1;
                phase_nxt = PH_FIRST;
                kind      = EV_ERROR;
              end else begin
                blk_nxt      = blk_p1[BW-1:0];
                nonempty_nxt = 1'b0;
                kind         = EV_BLOCK;
              end
            end
          end else if (held_nxt[LONG_BIT]) begin
            if ((held_nxt & JUMP_MASK) != '0) begin
              jump_nxt = 1'b1;
            end
            pdx_nxt   = long_delta(held_nxt, b);
            phase_nxt = PH_YFIRST;
          end else begin
            // Short X delta; this byte is the first byte of Y.
            pdx_nxt = short_delta(held_nxt);
            sdx     = short_delta(held_nxt);
            if (b[LONG_BIT]) begin
              if ((b & JUMP_MASK) != '0) begin
                jump_nxt = 1'b1;
              end
              held_nxt  = b;
              phase_nxt = PH_YSECOND;
            end else begin
              stitch_go = 1'b1;
              sdy       = short_delta(b);
            end
          end
        end
        PH_YFIRST: begin
          if (b[LONG_BIT]) begin
            if ((b & JUMP_MASK) != '0) begin
              jump_nxt = 1'b1;
            end
            held_nxt  = b;
            phase_nxt = PH_YSECOND;
          end else begin
            stitch_go = 1'b1;
            sdy       = short_delta(b);
          end
        end
        PH_YSECOND: begin
          stitch_go = 1'b1;
          sdy       = long_delta(held_nxt, b);
        end
        default: begin
          phase_nxt = PH_FIRST;
        end
      endcase
    end

    res.jump = 1'b0;
    if (stitch_go) begin
      emit         = 1'b1;
      kind         = EV_STITCH;
      res.jump     = jump_nxt;
      cur_x_nxt    = sat_add(cur_x_nxt, sdx);
      cur_y_nxt    = sat_add(cur_y_nxt, sdy);
      if (cur_x_nxt < min_x_nxt) min_x_nxt = cur_x_nxt;
      if (cur_x_nxt > max_x_nxt) max_x_nxt = cur_x_nxt;
      if (cur_y_nxt < min_y_nxt) min_y_nxt = cur_y_nxt;
      if (cur_y_nxt > max_y_nxt) max_y_nxt = cur_y_nxt;
      nonempty_nxt = 1'b1;
      jump_nxt     = 1'b0;
      pdx_nxt      = '0;
      phase_nxt    = PH_FIRST;
    end

    res.event_kind  = kind;
    res.pos_x       = to_out(cur_x_nxt);
    res.pos_y       = to_out(cur_y_nxt);
    res.block_index = BLKO_W'(blk_nxt);
    res.box_min_x   = to_out(min_x_nxt);
    res.box_max_x   = to_out(max_x_nxt);
    res.box_min_y   = to_out(min_y_nxt);
    res.box_max_y   = to_out(max_y_nxt);
  end

  assign res_push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_count_r <= COLOR_COUNT_RST;
      phase_r       <= PH_FIRST;
      held_r        <= '0;
      pdx_r         <= '0;
      jump_r        <= 1'b0;
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      min_x_r       <= CMAX;
      max_x_r       <= CMIN;
      min_y_r       <= CMAX;
      max_y_r       <= CMIN;
      blk_r         <= '0;
      nonempty_r    <= 1'b0;
      done_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        color_count_r <= cfg_wdata;
      end
      if (accept) begin
        phase_r    <= phase_nxt;
        held_r     <= held_nxt;
        pdx_r      <= pdx_nxt;
        jump_r     <= jump_nxt;
        cur_x_r    <= cur_x_nxt;
        cur_y_r    <= cur_y_nxt;
        min_x_r    <= min_x_nxt;
        max_x_r    <= max_x_nxt;
        min_y_r    <= min_y_nxt;
        max_y_r    <= max_y_nxt;
        blk_r      <= blk_nxt;
        nonempty_r <= nonempty_nxt;
        done_r     <= done_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/essd_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// essd_out_stage: result register
// Holds one finished event until the sink takes it.
// ----------------------------------------------------------------------------
module essd_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_push,
  input  wire essd_pkg::result_t res,
  output      logic              res_ready,
  essd_out_if.source             out_ch
);
  import essd_pkg::*;

  logic    valid_r;
  result_t data_r;

  // A new event may enter when the register is empty or is being drained.
  assign res_ready = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_push) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      data_r <= res;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.event_kind  = data_r.event_kind;
  assign out_ch.pos_x       = data_r.pos_x;
  assign out_ch.pos_y       = data_r.pos_y;
  assign out_ch.jump        = data_r.jump;
  assign out_ch.block_index = data_r.block_index;
  assign out_ch.box_min_x   = data_r.box_min_x;
  assign out_ch.box_max_x   = data_r.box_max_x;
  assign out_ch.box_min_y   = data_r.box_min_y;
  assign out_ch.box_max_y   = data_r.box_max_y;

endmodule

`default_nettype wire
